>>> design/tce_pkg.sv
// Shared types and codes for the terminal cursor engine.
`default_nettype none
package tce_pkg;
    localparam int CmdW = 5;
    localparam int OpW  = 4;

    localparam logic [CmdW-1:0] CMD_MOVE_ABS  = 5'd0;
    localparam logic [CmdW-1:0] CMD_MOVE_REL  = 5'd1;
    localparam logic [CmdW-1:0] CMD_CR        = 5'd2;
    localparam logic [CmdW-1:0] CMD_SCROLL_UP = 5'd3;
    localparam logic [CmdW-1:0] CMD_SCROLL_DN = 5'd4;
    localparam logic [CmdW-1:0] CMD_INDEX     = 5'd5;
    localparam logic [CmdW-1:0] CMD_REV_INDEX = 5'd6;
    localparam logic [CmdW-1:0] CMD_PUT_CHAR  = 5'd7;
    localparam logic [CmdW-1:0] CMD_CLR_RIGHT = 5'd8;
    localparam logic [CmdW-1:0] CMD_CLR_LEFT  = 5'd9;
    localparam logic [CmdW-1:0] CMD_CLR_TOP   = 5'd10;
    localparam logic [CmdW-1:0] CMD_CLR_ROW   = 5'd11;
    localparam logic [CmdW-1:0] CMD_CLR_BOT   = 5'd12;
    localparam logic [CmdW-1:0] CMD_CLR_ALL   = 5'd13;
    localparam logic [CmdW-1:0] CMD_INSERT    = 5'd14;
    localparam logic [CmdW-1:0] CMD_DELETE    = 5'd15;
    localparam logic [CmdW-1:0] CMD_ERASE     = 5'd16;
    localparam logic [CmdW-1:0] CMD_CUR_EN    = 5'd17;
    localparam logic [CmdW-1:0] CMD_SAVE      = 5'd18;
    localparam logic [CmdW-1:0] CMD_RESTORE   = 5'd19;
    localparam logic [CmdW-1:0] CMD_BLINK     = 5'd20;
    localparam logic [CmdW-1:0] CMD_REFRESH   = 5'd21;

    localparam logic [OpW-1:0] OP_DONE      = 4'd0;
    localparam logic [OpW-1:0] OP_INVERT    = 4'd1;
    localparam logic [OpW-1:0] OP_DRAW      = 4'd2;
    localparam logic [OpW-1:0] OP_CLR_ROWS  = 4'd3;
    localparam logic [OpW-1:0] OP_CLR_COLS  = 4'd4;
    localparam logic [OpW-1:0] OP_SCROLL_UP = 4'd5;
    localparam logic [OpW-1:0] OP_SCROLL_DN = 4'd6;
    localparam logic [OpW-1:0] OP_SHIFT_R   = 4'd7;
    localparam logic [OpW-1:0] OP_SHIFT_L   = 4'd8;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 5;
    localparam logic [CfgIdxW-1:0] REG_ORIGIN = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_WRAP   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_INSERT = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CONCEAL = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MTOP   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MBOT   = 3'd5;

    // Command as seen by the back end.
    typedef struct packed {
        logic [CmdW-1:0]  command;
        logic signed [10:0] row_arg;
        logic signed [10:0] col_arg;
        logic [7:0]       count;
        logic [7:0]       from_row_arg;
        logic [7:0]       glyph;
        logic             enable;
        logic             valid_cmd;   // code within the defined range
    } cmd_t;

    // One screen operation item.
    typedef struct packed {
        logic [OpW-1:0]     op;
        logic [4:0]         row;
        logic [6:0]         col;
        logic [8:0]         range_end;
        logic [10:0]        amount;
        logic [7:0]         glyph_out;
        logic signed [5:0]  report_row;
        logic [6:0]         report_col;
        logic               last;
    } res_t;
endpackage
`default_nettype wire

>>> design/tce_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
`default_nettype none
module tce_front #(
    parameter int Depth = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tce_pkg::cmd_t in_cmd,
    output logic               q_valid,
    input  wire logic          q_ready,
    output tce_pkg::cmd_t      q_cmd
);
    import tce_pkg::*;
    localparam int PW = $clog2(Depth);

    cmd_t            mem_reg [Depth];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            push, pop;
    cmd_t            cls;

    always_comb begin
        cls = in_cmd;
        cls.valid_cmd = (in_cmd.command <= CMD_REFRESH);
    end

    assign in_ready = (cnt_reg != (PW+1)'(Depth));
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_cmd = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= cls;
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == PW'(Depth-1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == PW'(Depth-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PW+1)'(Depth)) else $error("queue overflow");
    a_nopop: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == '0 |-> !pop) else $error("pop from empty queue");
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");
endmodule
`default_nettype wire

>>> design/tce_back.sv
// Back end: runs commands, keeps cursor state, emits one item per cycle unless stalled.
`default_nettype none
module tce_back #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 80,
    parameter int ON_TICKS    = 650,
    parameter int OFF_TICKS   = 350
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [tce_pkg::CfgIdxW-1:0]  cfg_idx,
    input  wire logic [tce_pkg::CfgDataW-1:0] cfg_data,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire tce_pkg::cmd_t                q_cmd,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output tce_pkg::res_t                     out_res
);
    import tce_pkg::*;

    // Signed work width covering row_arg plus any screen coordinate.
    localparam int W = 13;

    logic origin_reg, wrap_en_reg, insert_reg, conceal_reg;
    logic [4:0] mtop_reg, mbot_reg;
    logic [4:0] row_reg;
    logic [6:0] col_reg;
    logic wp_reg;
    logic [4:0] srow_reg;
    logic [6:0] scol_reg;
    logic swrap_reg;
    logic [9:0] blink_reg;
    logic bon_reg, shown_reg;

    // Items of the current command, drained one per cycle unless the output stalls.
    res_t buf_reg [5];
    logic [2:0] n_reg, idx_reg;
    logic busy_reg;
    logic ov_reg;
    res_t o_reg;

    logic signed [W-1:0] bot, top, rmax;
    logic signed [W-1:0] r0, c0, rr, cc, tmp;
    logic w0, placed;
    res_t it [5];
    logic [2:0] n;
    logic [9:0] bc;
    logic bo, sh;
    logic signed [W-1:0] offs, n_i;
    logic inside_m;

    function automatic logic signed [W-1:0] clampv(logic signed [W-1:0] v,
            logic signed [W-1:0] lo, logic signed [W-1:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic res_t mk(logic [OpW-1:0] op, logic signed [W-1:0] r,
            logic signed [W-1:0] c, logic signed [W-1:0] e, logic signed [W-1:0] a,
            logic [7:0] g);
        res_t x;
        x = '0;
        x.op = op; x.row = r[4:0]; x.col = c[6:0];
        x.range_end = e[8:0]; x.amount = a[10:0]; x.glyph_out = g;
        return x;
    endfunction

    assign q_ready = !busy_reg;
    assign out_valid = ov_reg;
    assign out_res = o_reg;

    always_comb begin
        bot = (mbot_reg == 5'd0) ? W'(1) :
              (W'(mbot_reg) > W'(SCREEN_ROWS) ? W'(SCREEN_ROWS) : W'(mbot_reg));
        top = (W'(mtop_reg) > bot - W'(1)) ? bot - W'(1) : W'(mtop_reg);
        rmax = W'(SCREEN_ROWS - 1);
        r0 = W'(row_reg); c0 = W'(col_reg); w0 = wp_reg;
        bc = blink_reg; bo = bon_reg; sh = shown_reg;
        n = '0;
        for (int k = 0; k < 5; k++) it[k] = '0;
        offs = origin_reg ? top : '0;
        n_i = W'(q_cmd.count);
        inside_m = 1'b0; placed = 1'b0; rr = '0; cc = '0; tmp = '0;

        if (q_cmd.valid_cmd && q_cmd.command != CMD_BLINK &&
            q_cmd.command != CMD_REFRESH && bc != '0) begin
            if (sh) begin it[n] = mk(OP_INVERT, r0, c0, '0, '0, '0); n = n + 1'b1; end
            bc = 10'(ON_TICKS); bo = 1'b1; sh = 1'b0;
        end

        if (q_cmd.valid_cmd) begin
            unique case (q_cmd.command)
                CMD_MOVE_ABS: begin
                    rr = offs + W'(q_cmd.row_arg); cc = W'(q_cmd.col_arg);
                    placed = 1'b1; inside_m = origin_reg;
                end
                CMD_MOVE_REL: begin
                    rr = r0 + W'(q_cmd.row_arg); cc = c0 + W'(q_cmd.col_arg);
                    placed = 1'b1; inside_m = (r0 >= top && r0 < bot) || origin_reg;
                end
                CMD_CR: begin c0 = '0; w0 = 1'b0; end
                CMD_SCROLL_UP, CMD_SCROLL_DN: begin
                    tmp = W'(q_cmd.from_row_arg) + offs;
                    if (tmp < bot) begin
                        it[n] = mk(q_cmd.command == CMD_SCROLL_UP ? OP_SCROLL_UP
                                   : OP_SCROLL_DN, tmp, '0, bot, n_i, '0);
                        n = n + 1'b1;
                    end
                end
                CMD_INDEX, CMD_PUT_CHAR: begin
                    if (q_cmd.command == CMD_PUT_CHAR) begin
                        n_i = W'(1);
                        if (!w0) n_i = '0;
                        else c0 = '0;
                    end
                    if (q_cmd.command == CMD_INDEX || w0) begin
                        w0 = (q_cmd.command == CMD_PUT_CHAR) ? 1'b0 : w0;
                        if (r0 >= top && r0 < bot) begin
                            if (r0 + n_i >= bot) begin
                                if (top < bot) begin
                                    it[n] = mk(OP_SCROLL_UP, top, '0, bot,
                                               n_i - (bot - W'(1) - r0), '0);
                                    n = n + 1'b1;
                                end
                                r0 = bot - W'(1);
                            end else r0 = r0 + n_i;
                        end else begin
                            rr = r0 + n_i; cc = c0; placed = 1'b1;
                            inside_m = origin_reg;
                        end
                    end
                end
                CMD_REV_INDEX: begin
                    if (r0 >= top && r0 < bot) begin
                        if (r0 - n_i < top) begin
                            it[n] = mk(OP_SCROLL_DN, top, '0, bot,
                                       n_i - (r0 - top), '0);
                            n = n + 1'b1;
                            r0 = top;
                        end else r0 = r0 - n_i;
                    end else begin
                        rr = r0 - n_i; cc = c0; placed = 1'b1;
                        inside_m = origin_reg;
                    end
                end
                CMD_CLR_RIGHT: begin
                    it[n] = mk(OP_CLR_COLS, r0, c0, W'(SCREEN_COLS), '0, '0);
                    n = n + 1'b1;
                end
                CMD_CLR_LEFT: begin
                    it[n] = mk(OP_CLR_COLS, r0, '0, c0 + W'(1), '0, '0); n = n + 1'b1;
                end
                CMD_CLR_TOP: begin
                    it[n] = mk(OP_CLR_ROWS, '0, '0, r0, '0, '0); n = n + 1'b1;
                end
                CMD_CLR_ROW: begin
                    it[n] = mk(OP_CLR_COLS, r0, '0, W'(SCREEN_COLS), '0, '0);
                    n = n + 1'b1;
                end
                CMD_CLR_BOT: begin
                    it[n] = mk(OP_CLR_ROWS, r0 + W'(1), '0, W'(SCREEN_ROWS), '0, '0);
                    n = n + 1'b1;
                end
                CMD_CLR_ALL: begin
                    it[n] = mk(OP_CLR_ROWS, '0, '0, W'(SCREEN_ROWS), '0, '0);
                    n = n + 1'b1;
                end
                CMD_INSERT, CMD_DELETE: begin
                    if (q_cmd.count != '0) begin
                        it[n] = mk(q_cmd.command == CMD_INSERT ? OP_SHIFT_R : OP_SHIFT_L,
                                   r0, c0, '0, n_i, '0);
                        n = n + 1'b1;
                    end
                end
                CMD_ERASE: begin
                    it[n] = mk(OP_CLR_COLS, r0, c0, c0 + n_i, '0, '0); n = n + 1'b1;
                end
                CMD_CUR_EN: begin
                    bc = q_cmd.enable ? 10'(ON_TICKS) : '0;
                    bo = q_cmd.enable; sh = 1'b0;
                end
                CMD_SAVE: ;
                CMD_RESTORE: begin
                    r0 = W'(srow_reg); c0 = W'(scol_reg); w0 = swrap_reg;
                    if (origin_reg) r0 = clampv(r0, top, bot - W'(1));
                end
                CMD_BLINK: begin
                    if (bc != '0) begin
                        bc = bc - 1'b1;
                        if (bc == '0) begin
                            bc = bo ? 10'(OFF_TICKS) : 10'(ON_TICKS);
                            bo = !bo;
                        end
                    end
                end
                CMD_REFRESH: begin
                    if (bo != sh) begin
                        sh = bo;
                        it[n] = mk(OP_INVERT, r0, c0, '0, '0, '0); n = n + 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (placed) begin
            r0 = inside_m ? clampv(rr, top, bot - W'(1)) : clampv(rr, '0, rmax);
            c0 = clampv(cc, '0, W'(SCREEN_COLS - 1));
            w0 = 1'b0;
        end

        // Character drawing after any wrap handling above.
        if (q_cmd.valid_cmd && q_cmd.command == CMD_PUT_CHAR) begin
            if (insert_reg) begin
                it[n] = mk(OP_SHIFT_R, r0, c0, '0, W'(1), '0); n = n + 1'b1;
            end
            if (!conceal_reg) begin
                it[n] = mk(OP_DRAW, r0, c0, '0, '0, q_cmd.glyph); n = n + 1'b1;
            end
            if (c0 == W'(SCREEN_COLS - 1)) begin
                if (wrap_en_reg) w0 = 1'b1;
            end else c0 = c0 + W'(1);
        end

        it[n] = '0;
        it[n].op = OP_DONE;
        it[n].report_row = 6'(r0 - offs);
        it[n].report_col = c0[6:0];
        it[n].last = 1'b1;
        n = n + 1'b1;
    end

    logic take;
    assign take = q_valid && !busy_reg;

    always_ff @(posedge aclk) begin
        if (take) for (int k = 0; k < 5; k++) buf_reg[k] <= it[k];
        if (!ov_reg || out_ready) o_reg <= buf_reg[idx_reg];
        if (!aresetn) begin
            origin_reg <= 1'b0; wrap_en_reg <= 1'b1; insert_reg <= 1'b0;
            conceal_reg <= 1'b0; mtop_reg <= '0; mbot_reg <= 5'd24;
            row_reg <= '0; col_reg <= '0; wp_reg <= 1'b0;
            srow_reg <= '0; scol_reg <= '0; swrap_reg <= 1'b0;
            blink_reg <= 10'(ON_TICKS); bon_reg <= 1'b1; shown_reg <= 1'b0;
            busy_reg <= 1'b0; n_reg <= '0; idx_reg <= '0; ov_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    REG_ORIGIN:  origin_reg  <= cfg_data[0];
                    REG_WRAP:    wrap_en_reg <= cfg_data[0];
                    REG_INSERT:  insert_reg  <= cfg_data[0];
                    REG_CONCEAL: conceal_reg <= cfg_data[0];
                    REG_MTOP:    mtop_reg    <= cfg_data;
                    REG_MBOT:    mbot_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (take) begin
                row_reg <= r0[4:0]; col_reg <= c0[6:0]; wp_reg <= w0;
                if (q_cmd.valid_cmd && q_cmd.command == CMD_SAVE) begin
                    srow_reg <= row_reg; scol_reg <= col_reg; swrap_reg <= wp_reg;
                end
                blink_reg <= bc; bon_reg <= bo; shown_reg <= sh;
                busy_reg <= 1'b1; n_reg <= n; idx_reg <= '0;
            end
            if (!ov_reg || out_ready) begin
                ov_reg <= busy_reg;
                if (busy_reg) begin
                    if (idx_reg + 1'b1 == n_reg) busy_reg <= 1'b0;
                    else idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_res.last |-> out_res.op == OP_DONE) else $error("last not on done");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg < n_reg) else $error("drain index past run");
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> busy_reg) else $error("command taken without run");
endmodule
`default_nettype wire

>>> design/terminal_cursor_engine.sv
// Top level of the terminal cursor engine: command queue front end and executing back end.
//
//  channel  | ports                    | carries
//  ---------+--------------------------+----------------------------------------
//  command  | s_tvalid s_tready s_tdata| one terminal command item
//  result   | m_tvalid m_tready m_tdata| screen operation items, m_tlast on done
//  config   | cfg_we cfg_idx cfg_data  | register writes, no handshake
//
// A command is evaluated in the back end as it is taken, then its run of one to
// five result items drains at one item per cycle through the output register
// while the result side is ready; no new command is taken until the run drains.
// The two-entry queue lets the front side keep accepting while a run drains. Reset
// is synchronous and active low; it clears the queue, cursor state and registers.
// Stalls on the result side hold the output register and back up into the queue.
`default_nettype none
module terminal_cursor_engine #(
    parameter int SCREEN_ROWS = 24,
    parameter int SCREEN_COLS = 80,
    parameter int ON_TICKS    = 650,
    parameter int OFF_TICKS   = 350
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[4:0] row_arg[15:5] col_arg[26:16] count[34:27] from_row_arg[42:35]
    // glyph[50:43] enable[51]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // op[3:0] row[8:4] col[15:9] range_end[24:16] amount[35:25] glyph_out[43:36]
    // report_row[49:44] report_col[56:50]
    output logic [63:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [tce_pkg::CfgIdxW-1:0]  cfg_idx,
    input  wire logic [tce_pkg::CfgDataW-1:0] cfg_data
);
    import tce_pkg::*;

    cmd_t in_c, q_c;
    logic q_v, q_r;
    res_t r;

    // Unpack the command item; the class bit is filled by the front end.
    always_comb begin
        in_c = '0;
        in_c.command      = s_tdata[4:0];
        in_c.row_arg      = s_tdata[15:5];
        in_c.col_arg      = s_tdata[26:16];
        in_c.count        = s_tdata[34:27];
        in_c.from_row_arg = s_tdata[42:35];
        in_c.glyph        = s_tdata[50:43];
        in_c.enable       = s_tdata[51];
    end

    tce_front #(.Depth(2)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_c),
        .q_valid(q_v), .q_ready(q_r), .q_cmd(q_c)
    );

    tce_back #(.SCREEN_ROWS(SCREEN_ROWS), .SCREEN_COLS(SCREEN_COLS),
               .ON_TICKS(ON_TICKS), .OFF_TICKS(OFF_TICKS)) u_back (
        .aclk, .aresetn, .cfg_we, .cfg_idx, .cfg_data,
        .q_valid(q_v), .q_ready(q_r), .q_cmd(q_c),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(r)
    );

    assign m_tdata = {7'd0, r.report_col, r.report_row, r.glyph_out, r.amount,
                      r.range_end, r.col, r.row, r.op};
    assign m_tlast = r.last;
endmodule
`default_nettype wire

>>> sim/terminal_cursor_engine_tb.sv
// Testbench for the terminal cursor engine: predicts screen operation items per command.
`timescale 1ns / 100ps
`default_nettype none
module terminal_cursor_engine_tb;
    import tce_pkg::*;

    localparam int ROWS = 24;
    localparam int COLS = 80;
    localparam int ON_T = 650;
    localparam int OFF_T = 350;
    localparam int STALL_LIMIT = 2000;

    // Command item fields as packed into s_tdata, highest bits first.
    typedef struct packed {
        logic [3:0]         pad;
        logic               enable;
        logic [7:0]         glyph;
        logic [7:0]         from_row_arg;
        logic [7:0]         count;
        logic signed [10:0] col_arg;
        logic signed [10:0] row_arg;
        logic [4:0]         command;
    } cmd_item_t;

    // Screen operation fields as on m_tdata, with the m_tlast flag on top.
    typedef struct packed {
        logic               last;
        logic [6:0]         report_col;
        logic signed [5:0]  report_row;
        logic [7:0]         glyph_out;
        logic [10:0]        amount;
        logic [8:0]         range_end;
        logic [6:0]         col;
        logic [4:0]         row;
        logic [3:0]         op;
    } screen_op_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [55:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [63:0] m_tdata;
    wire         m_tlast;
    logic        cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    terminal_cursor_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the engine's registers and cursor state.
    bit origin_on, auto_wrap, insert_on, conceal;
    int region_top, region_bot;
    int cur_row, cur_col, saved_row, saved_col;
    bit wrap_pending, saved_wrap, blink_on, shown_inverted;
    int blink_count;

    cmd_item_t  pending_cmds[$];
    screen_op_t expected_ops[$];
    int  errors = 0;
    bit  idle_allowed = 1'b1;
    bit  stim_done = 1'b0;
    int  quiet_cycles = 0;

    function automatic int clampi(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_bottom();
        return clampi(region_bot, 1, ROWS);
    endfunction

    function automatic int eff_top();
        int b;
        b = eff_bottom();
        return (region_top > b - 1) ? b - 1 : region_top;
    endfunction

    function automatic bit in_region();
        return cur_row >= eff_top() && cur_row < eff_bottom();
    endfunction

    // Queues one expected screen operation; a run never exceeds five items.
    task automatic push_op(logic [3:0] op, int row, int col, int rend, int amt,
                           int g, int rrow, int rcol, bit last, inout int n);
        screen_op_t o;
        if (n >= 5) return;
        o.op = op; o.row = row[4:0]; o.col = col[6:0]; o.range_end = rend[8:0];
        o.amount = amt[10:0]; o.glyph_out = g[7:0]; o.report_row = rrow[5:0];
        o.report_col = rcol[6:0]; o.last = last;
        expected_ops.push_back(o);
        n++;
    endtask

    task automatic place_cursor(int r, int c, bit to_margins);
        if (to_margins) r = clampi(r, eff_top(), eff_bottom() - 1);
        else r = clampi(r, 0, ROWS - 1);
        cur_row = r;
        cur_col = clampi(c, 0, COLS - 1);
        wrap_pending = 1'b0;
    endtask

    task automatic scroll_op(logic [3:0] op, int from, int amt, inout int n);
        if (from < eff_bottom()) push_op(op, from, 0, eff_bottom(), amt, 0, 0, 0, 0, n);
    endtask

    task automatic line_feed(int k, inout int n);
        int top, bot;
        top = eff_top();
        bot = eff_bottom();
        if (in_region()) begin
            if (cur_row + k >= bot) begin
                scroll_op(OP_SCROLL_UP, top, k - (bot - 1 - cur_row), n);
                cur_row = bot - 1;
            end else begin
                cur_row += k;
            end
        end else begin
            place_cursor(cur_row + k, cur_col, origin_on);
        end
    endtask

    task automatic reverse_feed(int k, inout int n);
        int top;
        top = eff_top();
        if (in_region()) begin
            if (cur_row - k < top) begin
                scroll_op(OP_SCROLL_DN, top, k - (cur_row - top), n);
                cur_row = top;
            end else begin
                cur_row -= k;
            end
        end else begin
            place_cursor(cur_row - k, cur_col, origin_on);
        end
    endtask

    // Works out the run of screen operations that one command causes.
    task automatic predict_screen_ops(cmd_item_t c);
        int n, offs, ra, ca, cnt, frm;
        n = 0;
        ra = c.row_arg;
        ca = c.col_arg;
        cnt = c.count;
        frm = c.from_row_arg;
        // Any defined command other than blink and refresh takes the cursor off screen.
        if (c.command != CMD_BLINK && c.command != CMD_REFRESH && c.command <= CMD_REFRESH) begin
            if (blink_count != 0) begin
                if (shown_inverted) push_op(OP_INVERT, cur_row, cur_col, 0, 0, 0, 0, 0, 0, n);
                blink_count = ON_T;
                blink_on = 1'b1;
                shown_inverted = 1'b0;
            end
        end
        case (c.command)
            CMD_MOVE_ABS: begin
                offs = origin_on ? eff_top() : 0;
                place_cursor(offs + ra, ca, origin_on);
            end
            CMD_MOVE_REL: place_cursor(cur_row + ra, cur_col + ca, in_region() || origin_on);
            CMD_CR: begin
                cur_col = 0;
                wrap_pending = 1'b0;
            end
            CMD_SCROLL_UP, CMD_SCROLL_DN: begin
                offs = origin_on ? eff_top() : 0;
                scroll_op(c.command == CMD_SCROLL_UP ? OP_SCROLL_UP : OP_SCROLL_DN,
                          frm + offs, cnt, n);
            end
            CMD_INDEX: line_feed(cnt, n);
            CMD_REV_INDEX: reverse_feed(cnt, n);
            CMD_PUT_CHAR: begin
                if (wrap_pending) begin
                    cur_col = 0;
                    wrap_pending = 1'b0;
                    line_feed(1, n);
                end
                if (insert_on) push_op(OP_SHIFT_R, cur_row, cur_col, 0, 1, 0, 0, 0, 0, n);
                if (!conceal) push_op(OP_DRAW, cur_row, cur_col, 0, 0, c.glyph, 0, 0, 0, n);
                if (cur_col == COLS - 1) begin
                    if (auto_wrap) wrap_pending = 1'b1;
                end else begin
                    cur_col++;
                end
            end
            CMD_CLR_RIGHT: push_op(OP_CLR_COLS, cur_row, cur_col, COLS, 0, 0, 0, 0, 0, n);
            CMD_CLR_LEFT: push_op(OP_CLR_COLS, cur_row, 0, cur_col + 1, 0, 0, 0, 0, 0, n);
            CMD_CLR_TOP: push_op(OP_CLR_ROWS, 0, 0, cur_row, 0, 0, 0, 0, 0, n);
            CMD_CLR_ROW: push_op(OP_CLR_COLS, cur_row, 0, COLS, 0, 0, 0, 0, 0, n);
            CMD_CLR_BOT: push_op(OP_CLR_ROWS, cur_row + 1, 0, ROWS, 0, 0, 0, 0, 0, n);
            CMD_CLR_ALL: push_op(OP_CLR_ROWS, 0, 0, ROWS, 0, 0, 0, 0, 0, n);
            CMD_INSERT, CMD_DELETE: begin
                if (cnt > 0)
                    push_op(c.command == CMD_INSERT ? OP_SHIFT_R : OP_SHIFT_L,
                            cur_row, cur_col, 0, cnt, 0, 0, 0, 0, n);
            end
            CMD_ERASE: push_op(OP_CLR_COLS, cur_row, cur_col, cur_col + cnt, 0, 0, 0, 0, 0, n);
            CMD_CUR_EN: begin
                blink_count = c.enable ? ON_T : 0;
                blink_on = c.enable;
                shown_inverted = 1'b0;
            end
            CMD_SAVE: begin
                saved_row = cur_row;
                saved_col = cur_col;
                saved_wrap = wrap_pending;
            end
            CMD_RESTORE: begin
                cur_row = saved_row;
                cur_col = saved_col;
                wrap_pending = saved_wrap;
                if (origin_on) cur_row = clampi(cur_row, eff_top(), eff_bottom() - 1);
            end
            CMD_BLINK: begin
                if (blink_count != 0) begin
                    blink_count--;
                    if (blink_count == 0) begin
                        blink_on = !blink_on;
                        blink_count = blink_on ? ON_T : OFF_T;
                    end
                end
            end
            CMD_REFRESH: begin
                if (blink_on != shown_inverted) begin
                    shown_inverted = blink_on;
                    push_op(OP_INVERT, cur_row, cur_col, 0, 0, 0, 0, 0, 0, n);
                end
            end
            default: ;
        endcase
        offs = origin_on ? eff_top() : 0;
        push_op(OP_DONE, 0, 0, 0, 0, 0, cur_row - offs, cur_col, 1, n);
    endtask

    // Driver: presents queued commands, with random idle bursts while allowed.
    int src_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_screen_ops(cmd_item_t'(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    s_tdata <= pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    if (idle_allowed && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and drives random back pressure.
    int sink_gap = 0;
    always @(posedge aclk) begin
        screen_op_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = screen_op_t'({m_tlast, m_tdata[56:0]});
                if (expected_ops.size() == 0) begin
                    $error("unexpected screen op item: op=%0d", got.op);
                    errors++;
                end else begin
                    want = expected_ops.pop_front();
                    if (got.op != want.op) begin
                        $error("op: expected %0d, got %0d", want.op, got.op); errors++;
                    end
                    if (got.row != want.row) begin
                        $error("row: expected %0d, got %0d", want.row, got.row); errors++;
                    end
                    if (got.col != want.col) begin
                        $error("col: expected %0d, got %0d", want.col, got.col); errors++;
                    end
                    if (got.range_end != want.range_end) begin
                        $error("range_end: expected %0d, got %0d", want.range_end,
                               got.range_end); errors++;
                    end
                    if (got.amount != want.amount) begin
                        $error("amount: expected %0d, got %0d", want.amount, got.amount);
                        errors++;
                    end
                    if (got.glyph_out != want.glyph_out) begin
                        $error("glyph_out: expected %0d, got %0d", want.glyph_out,
                               got.glyph_out); errors++;
                    end
                    if (got.report_row != want.report_row) begin
                        $error("report_row: expected %0d, got %0d", want.report_row,
                               got.report_row); errors++;
                    end
                    if (got.report_col != want.report_col) begin
                        $error("report_col: expected %0d, got %0d", want.report_col,
                               got.report_col); errors++;
                    end
                    if (got.last != want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last); errors++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 6);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles without any accepted item; past the limit it ends the test as failed.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Register write at a clock edge; the engine must be idle.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val[CfgDataW-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN: origin_on = val[0];
            REG_WRAP: auto_wrap = val[0];
            REG_INSERT: insert_on = val[0];
            REG_CONCEAL: conceal = val[0];
            REG_MTOP: region_top = val & 31;
            REG_MBOT: region_bot = val & 31;
            default: ;
        endcase
    endtask

    function automatic cmd_item_t make_cmd(logic [4:0] cmd, int ra, int ca, int cnt,
                                           int frm, int g, bit en);
        cmd_item_t c;
        c = '0;
        c.command = cmd; c.row_arg = ra[10:0]; c.col_arg = ca[10:0];
        c.count = cnt[7:0]; c.from_row_arg = frm[7:0]; c.glyph = g[7:0]; c.enable = en;
        return c;
    endfunction

    // Random command; mostly sensible moves and text, sometimes wild arguments.
    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        int pick;
        c = cmd_item_t'({$urandom(), 24'($urandom())});
        c.pad = '0;
        pick = $urandom_range(0, 99);
        if (pick < 30) c.command = CMD_PUT_CHAR;
        else if (pick < 35) c.command = CMD_REFRESH;
        else if (pick < 40) c.command = CMD_BLINK;
        else if (pick < 43) c.command = 5'($urandom_range(22, 31));
        else c.command = 5'($urandom_range(0, 21));
        if ($urandom_range(0, 3) != 0) begin
            c.row_arg = 11'($signed($urandom_range(0, 60)) - 30);
            c.col_arg = 11'($signed($urandom_range(0, 180)) - 90);
            c.count = 8'($urandom_range(0, 30));
            c.from_row_arg = 8'($urandom_range(0, 26));
        end
        return c;
    endfunction

    task automatic drain_and_settle();
        wait (pending_cmds.size() == 0 && !s_tvalid && expected_ops.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int phase, k;
        origin_on = 0; auto_wrap = 1; insert_on = 0; conceal = 0;
        region_top = 0; region_bot = 24;
        cur_row = 0; cur_col = 0; wrap_pending = 0;
        saved_row = 0; saved_col = 0; saved_wrap = 0;
        blink_count = ON_T; blink_on = 1; shown_inverted = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, every command and the listed corner cases.
        pending_cmds.push_back(make_cmd(CMD_REFRESH, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_MOVE_ABS, 1023, 1023, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_PUT_CHAR, 0, 0, 0, 0, 255, 0));
        pending_cmds.push_back(make_cmd(CMD_PUT_CHAR, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_MOVE_REL, -1024, -1024, 255, 255, 255, 1));
        pending_cmds.push_back(make_cmd(CMD_INDEX, 0, 0, 255, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_REV_INDEX, 0, 0, 255, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_UP, 0, 0, 0, 255, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SCROLL_DN, 0, 0, 0, 3, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DELETE, 0, 0, 255, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_ERASE, 0, 0, 255, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_ERASE, 0, 0, 0, 0, 0, 0));
        for (int i = CMD_CLR_RIGHT; i <= CMD_CLR_ALL; i++)
            pending_cmds.push_back(make_cmd(5'(i), 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_SAVE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CR, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_RESTORE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CUR_EN, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_BLINK, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CUR_EN, 0, 0, 0, 0, 0, 1));
        pending_cmds.push_back(make_cmd(5'd31, 0, 0, 0, 0, 0, 0));
        drain_and_settle();

        // Random phases under varied register settings, extremes included.
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MTOP, 5); write_reg(REG_MBOT, 20); write_reg(REG_ORIGIN, 1);
                    write_reg(REG_INSERT, 1);
                end
                1: begin
                    write_reg(REG_WRAP, 0); write_reg(REG_CONCEAL, 1); write_reg(REG_MBOT, 0);
                    write_reg(REG_MTOP, 31);
                end
                2: begin
                    write_reg(REG_ORIGIN, 0); write_reg(REG_MTOP, 23); write_reg(REG_MBOT, 31);
                    write_reg(REG_CONCEAL, 0); write_reg(REG_INSERT, 0);
                end
                3: begin
                    write_reg(REG_WRAP, 1); write_reg(REG_MTOP, 0); write_reg(REG_MBOT, 1);
                    write_reg(REG_ORIGIN, 1);
                end
                4: begin
                    write_reg(REG_MTOP, $urandom_range(0, 31));
                    write_reg(REG_MBOT, $urandom_range(0, 31));
                    write_reg(REG_ORIGIN, $urandom_range(0, 1));
                end
                default: begin
                    // Final part: reset-like settings, no idling on either side.
                    write_reg(REG_ORIGIN, 0); write_reg(REG_MTOP, 0); write_reg(REG_MBOT, 24);
                    idle_allowed = 1'b0;
                end
            endcase
            for (k = 0; k < 52; k++) pending_cmds.push_back(random_cmd());
            drain_and_settle();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

>>> terminal_cursor_engine.f
design/tce_pkg.sv
design/tce_front.sv
design/tce_back.sv
design/terminal_cursor_engine.sv
sim/terminal_cursor_engine_tb.sv
